// ===== rtl/core/utf8tl_pkg.sv =====
// Shared types and constants for the UTF-8 text line decoder.
// No dependencies; used by utf8tl_ctrl, utf8tl_dp and utf8_text_line_decoder.
package utf8tl_pkg;

    localparam logic [7:0]  CHR_TAB = 8'h09;
    localparam logic [7:0]  CHR_LF  = 8'h0A;
    localparam logic [7:0]  CHR_CR  = 8'h0D;
    localparam logic [20:0] CHR_SPACE = 21'h00_0020;

    localparam logic [20:0] BOM_CP      = 21'h00_FEFF;
    localparam logic [20:0] MAX_CP      = 21'h10_FFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h01_0000;
    localparam logic [20:0] BMP_MAX     = 21'h00_FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00_D800;
    localparam logic [20:0] SURR_HI     = 21'h00_DFFF;
    localparam logic [20:0] HIGH_SURR   = 21'h00_D800;
    localparam logic [20:0] LOW_SURR    = 21'h00_DC00;

    localparam logic [4:0]  MAX_RESULTS = 5'd17;
    localparam logic [4:0]  TAB_RESET   = 5'd4;
    localparam logic [4:0]  TAB_MAX     = 5'd16;

    localparam logic        REG_TAB_SIZE   = 1'b0;
    localparam logic        REG_UTF16_MODE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPACE,
        ST_LOW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic space;
        logic low;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic       buf_empty;
        logic       can_push;
        logic       is_tab;
        logic       is_pair;
        logic       space_last;
        logic [4:0] res_count;
    } dp_status_t;

endpackage

// ===== rtl/core/utf8tl_ctrl.sv =====
// Request sequencer for the UTF-8 text line decoder.
// Depends on utf8tl_pkg (state_t, dp_cmd_t, dp_status_t).
module utf8tl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  utf8tl_pkg::dp_status_t status,
    output utf8tl_pkg::dp_cmd_t    cmd
);

    utf8tl_pkg::state_t state_reg;
    utf8tl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= utf8tl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            utf8tl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = utf8tl_pkg::ST_SCAN;
                end
            end
            utf8tl_pkg::ST_SCAN:
            begin
                if (status.buf_empty)
                begin
                    state_next = utf8tl_pkg::ST_DONE;
                end
                else if (status.can_push)
                begin
                    if (status.is_tab)
                    begin
                        state_next = utf8tl_pkg::ST_SPACE;
                    end
                    else if (status.is_pair)
                    begin
                        state_next = utf8tl_pkg::ST_LOW;
                    end
                end
            end
            utf8tl_pkg::ST_SPACE:
            begin
                if (status.can_push && status.space_last)
                begin
                    state_next = utf8tl_pkg::ST_SCAN;
                end
            end
            utf8tl_pkg::ST_LOW:
            begin
                if (status.can_push)
                begin
                    state_next = utf8tl_pkg::ST_SCAN;
                end
            end
            utf8tl_pkg::ST_DONE:
            begin
                if (status.can_push)
                begin
                    state_next = utf8tl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = utf8tl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            utf8tl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            utf8tl_pkg::ST_SCAN:
            begin
                cmd.scan = !status.buf_empty && status.can_push;
            end
            utf8tl_pkg::ST_SPACE:
            begin
                cmd.space = status.can_push;
            end
            utf8tl_pkg::ST_LOW:
            begin
                cmd.low = status.can_push;
            end
            utf8tl_pkg::ST_DONE:
            begin
                cmd.finish = status.can_push;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/utf8tl_dp.sv =====
// Datapath of the UTF-8 text line decoder: byte window, sequence decode,
// column tracking, configuration registers and the two-entry result stage.
// Depends on utf8tl_pkg.
module utf8tl_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [4:0]             cfg_data,
    input  logic [7:0]             in_byte,
    input  logic                   in_first,
    input  logic                   in_last,
    input  utf8tl_pkg::dp_cmd_t    cmd,
    output utf8tl_pkg::dp_status_t status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [20:0]            out_unit,
    output logic                   out_brk,
    output logic                   out_last
);

    // column modulo tab size; col < 16, ts in 1..16
    function automatic logic [3:0] col_mod(input logic [3:0] col, input logic [4:0] ts);
        logic [4:0] r;
        r = '0;
        for (int i = 3; i >= 0; i--)
        begin
            r = {r[3:0], col[i]};
            if (r >= ts)
            begin
                r = r - ts;
            end
        end
        return r[3:0];
    endfunction

    logic [4:0]       tab_size_reg, tab_size_next;
    logic             utf16_reg, utf16_next;
    logic [3:0][7:0]  buf_reg, buf_next;
    logic [2:0]       n_reg, n_next;
    logic [1:0]       held_count_reg, held_count_next;
    logic [3:0]       col_reg, col_next;
    logic             acr_reg, acr_next;
    logic             ads_reg, ads_next;
    logic             end_reg, end_next;
    logic [4:0]       res_count_reg, res_count_next;
    logic [4:0]       space_cnt_reg, space_cnt_next;
    logic [9:0]       low_unit_reg, low_unit_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [20:0]      pend_unit_reg, pend_unit_next;
    logic             pend_brk_reg, pend_brk_next;
    logic             out_valid_reg, out_valid_next;
    logic [20:0]      out_unit_reg, out_unit_next;
    logic             out_brk_reg, out_brk_next;
    logic             out_last_reg, out_last_next;

    logic [4:0]  ts;
    logic [3:0]  rem;
    logic [4:0]  rem_inc;
    logic [3:0]  col_adv;
    logic [7:0]  lead;
    logic [2:0]  seq_len;
    logic        lead_bad;
    logic [20:0] cp_min;
    logic        cont_bad;
    logic        too_short;
    logic [20:0] cp_full;
    logic        range_bad;
    logic        hold;
    logic        seq_bad;
    logic [20:0] cp_emit;
    logic        skip_bom;
    logic        need_pair;
    logic [20:0] supp_off;
    logic [20:0] unit_first;
    logic [2:0]  used;
    logic [1:0]  hc_eff;
    logic        put_req;
    logic        put_ok;
    logic [20:0] put_unit;
    logic        put_brk;
    logic        can_push;

    always_comb
    begin
        if (tab_size_reg == 5'd0)
        begin
            ts = 5'd1;
        end
        else if (tab_size_reg > utf8tl_pkg::TAB_MAX)
        begin
            ts = utf8tl_pkg::TAB_MAX;
        end
        else
        begin
            ts = tab_size_reg;
        end
        rem     = col_mod(col_reg, ts);
        rem_inc = {1'b0, rem} + 5'd1;
        col_adv = (rem_inc == ts) ? 4'd0 : rem_inc[3:0];
    end

    // decode of the sequence that starts at the window head
    always_comb
    begin
        lead     = buf_reg[0];
        seq_len  = 3'd1;
        lead_bad = 1'b0;
        cp_min   = '0;
        if (lead >= 8'hC2 && lead <= 8'hDF)
        begin
            seq_len = 3'd2;
            cp_min  = 21'h00_0080;
        end
        else if (lead >= 8'hE0 && lead <= 8'hEF)
        begin
            seq_len = 3'd3;
            cp_min  = 21'h00_0800;
        end
        else if (lead >= 8'hF0 && lead <= 8'hF4)
        begin
            seq_len = 3'd4;
            cp_min  = utf8tl_pkg::SUPP_BASE;
        end
        else
        begin
            lead_bad = 1'b1;
        end

        cont_bad = (seq_len > 3'd1 && n_reg > 3'd1 && buf_reg[1][7:6] != 2'b10)
                || (seq_len > 3'd2 && n_reg > 3'd2 && buf_reg[2][7:6] != 2'b10)
                || (seq_len > 3'd3 && n_reg > 3'd3 && buf_reg[3][7:6] != 2'b10);
        too_short = n_reg < seq_len;

        case (seq_len)
            3'd2:    cp_full = {10'd0, lead[4:0], buf_reg[1][5:0]};
            3'd3:    cp_full = {5'd0, lead[3:0], buf_reg[1][5:0], buf_reg[2][5:0]};
            3'd4:    cp_full = {lead[2:0], buf_reg[1][5:0], buf_reg[2][5:0],
                                buf_reg[3][5:0]};
            default: cp_full = {13'd0, lead};
        endcase

        range_bad = (cp_full < cp_min)
                 || (cp_full >= utf8tl_pkg::SURR_LO && cp_full <= utf8tl_pkg::SURR_HI)
                 || (cp_full > utf8tl_pkg::MAX_CP);
        hold    = !lead_bad && !cont_bad && too_short && !end_reg;
        seq_bad = lead_bad || cont_bad || (too_short && end_reg)
               || (!too_short && range_bad);
        cp_emit  = seq_bad ? {13'd0, lead} : cp_full;
        skip_bom = !seq_bad && ads_reg && (cp_full == utf8tl_pkg::BOM_CP);
        need_pair = utf16_reg && (cp_emit > utf8tl_pkg::BMP_MAX);
        supp_off  = cp_emit - utf8tl_pkg::SUPP_BASE;
        unit_first = need_pair ? (utf8tl_pkg::HIGH_SURR + {11'd0, supp_off[19:10]})
                               : cp_emit;
        used = seq_bad ? 3'd1 : seq_len;
    end

    assign can_push = !out_valid_reg || out_ready;

    always_comb
    begin
        tab_size_next   = tab_size_reg;
        utf16_next      = utf16_reg;
        buf_next        = buf_reg;
        n_next          = n_reg;
        held_count_next = held_count_reg;
        col_next        = col_reg;
        acr_next        = acr_reg;
        ads_next        = ads_reg;
        end_next        = end_reg;
        res_count_next  = res_count_reg;
        space_cnt_next  = space_cnt_reg;
        low_unit_next   = low_unit_reg;
        hc_eff          = in_first ? 2'd0 : held_count_reg;
        put_req         = 1'b0;
        put_unit        = '0;
        put_brk         = 1'b0;

        if (cfg_we)
        begin
            if (cfg_index == utf8tl_pkg::REG_TAB_SIZE)
            begin
                tab_size_next = cfg_data;
            end
            else
            begin
                utf16_next = cfg_data[0];
            end
        end

        if (cmd.load)
        begin
            buf_next[hc_eff] = in_byte;
            n_next           = {1'b0, hc_eff} + 3'd1;
            held_count_next  = 2'd0;
            end_next         = in_last;
            res_count_next   = 5'd0;
            if (in_first)
            begin
                col_next = 4'd0;
                acr_next = 1'b0;
                ads_next = 1'b1;
            end
        end

        if (cmd.scan)
        begin
            ads_next = 1'b0;
            if (lead == utf8tl_pkg::CHR_LF && acr_reg)
            begin
                acr_next = 1'b0;
                buf_next = buf_reg >> 8;
                n_next   = n_reg - 3'd1;
            end
            else if (lead == utf8tl_pkg::CHR_CR || lead == utf8tl_pkg::CHR_LF)
            begin
                put_req  = 1'b1;
                put_brk  = 1'b1;
                col_next = 4'd0;
                acr_next = (lead == utf8tl_pkg::CHR_CR);
                buf_next = buf_reg >> 8;
                n_next   = n_reg - 3'd1;
            end
            else
            begin
                acr_next = 1'b0;
                if (lead == utf8tl_pkg::CHR_TAB)
                begin
                    space_cnt_next = ts - {1'b0, rem};
                    col_next       = 4'd0;
                    buf_next       = buf_reg >> 8;
                    n_next         = n_reg - 3'd1;
                end
                else if (hold)
                begin
                    // incomplete sequence waits for the next byte
                    held_count_next = n_reg[1:0];
                    n_next          = 3'd0;
                    ads_next        = ads_reg;
                end
                else
                begin
                    if (!skip_bom)
                    begin
                        put_req  = 1'b1;
                        put_unit = unit_first;
                        col_next = col_adv;
                    end
                    low_unit_next = supp_off[9:0];
                    buf_next      = buf_reg >> {used, 3'b000};
                    n_next        = n_reg - used;
                end
            end
        end

        if (cmd.space)
        begin
            put_req        = 1'b1;
            put_unit       = utf8tl_pkg::CHR_SPACE;
            space_cnt_next = space_cnt_reg - 5'd1;
        end

        if (cmd.low)
        begin
            put_req  = 1'b1;
            put_unit = utf8tl_pkg::LOW_SURR + {11'd0, low_unit_reg};
        end

        if (cmd.finish && end_reg)
        begin
            held_count_next = 2'd0;
            col_next        = 4'd0;
            acr_next        = 1'b0;
            ads_next        = 1'b1;
        end

        put_ok = put_req && (res_count_reg < utf8tl_pkg::MAX_RESULTS);
        if (put_ok)
        begin
            res_count_next = res_count_reg + 5'd1;
        end
    end

    // pending result waits until the next one (or step end) decides its last flag
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_unit_next  = pend_unit_reg;
        pend_brk_next   = pend_brk_reg;
        out_valid_next  = out_valid_reg;
        out_unit_next   = out_unit_reg;
        out_brk_next    = out_brk_reg;
        out_last_next   = out_last_reg;

        if (pend_valid_reg && (put_ok || cmd.finish))
        begin
            out_valid_next = 1'b1;
            out_unit_next  = pend_unit_reg;
            out_brk_next   = pend_brk_reg;
            out_last_next  = cmd.finish;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (put_ok)
        begin
            pend_valid_next = 1'b1;
            pend_unit_next  = put_unit;
            pend_brk_next   = put_brk;
        end
        else if (cmd.finish)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_size_reg   <= utf8tl_pkg::TAB_RESET;
            utf16_reg      <= 1'b1;
            n_reg          <= 3'd0;
            held_count_reg <= 2'd0;
            col_reg        <= 4'd0;
            acr_reg        <= 1'b0;
            ads_reg        <= 1'b1;
            end_reg        <= 1'b0;
            res_count_reg  <= 5'd0;
            space_cnt_reg  <= 5'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            tab_size_reg   <= tab_size_next;
            utf16_reg      <= utf16_next;
            n_reg          <= n_next;
            held_count_reg <= held_count_next;
            col_reg        <= col_next;
            acr_reg        <= acr_next;
            ads_reg        <= ads_next;
            end_reg        <= end_next;
            res_count_reg  <= res_count_next;
            space_cnt_reg  <= space_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg       <= buf_next;
        low_unit_reg  <= low_unit_next;
        pend_unit_reg <= pend_unit_next;
        pend_brk_reg  <= pend_brk_next;
        out_unit_reg  <= out_unit_next;
        out_brk_reg   <= out_brk_next;
        out_last_reg  <= out_last_next;
    end

    assign status.buf_empty  = (n_reg == 3'd0);
    assign status.can_push   = can_push;
    assign status.is_tab     = (lead == utf8tl_pkg::CHR_TAB);
    assign status.is_pair    = lead[7] && !hold && !skip_bom && need_pair;
    assign status.space_last = (space_cnt_reg == 5'd1);
    assign status.res_count  = res_count_reg;

    assign out_valid = out_valid_reg;
    assign out_unit  = out_unit_reg;
    assign out_brk   = out_brk_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/core/utf8_text_line_decoder.sv =====
// UTF-8 text line decoder, top level: stream ports, configuration port and
// the controller / datapath pair. Depends on utf8tl_pkg, utf8tl_ctrl, utf8tl_dp.
//
// One document byte is taken per input request. A plain byte passes through
// the accept, decode, empty check and close steps. Every further sequence in the
// window (Latin-1 fallback of held bytes), every tab space and every low
// surrogate adds a step of its own, so a tab of k spaces adds k space steps. A byte
// that yields no result (held lead, swallowed LF, dropped byte order mark)
// still passes through all of these steps. The decode sequencer handles one
// sequence or one result per cycle while the output register is free. Results
// pass through a pending stage and an output register; the idle sequencer takes
// the next byte while the output stalls, but every decode, space, low surrogate
// and close step waits until the output register is free.
module utf8_text_line_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [0:0]  s_tuser,    // [0] first_in_doc
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [20:0] code_unit, [23:21] zero
    output logic [0:0]  m_tuser,    // [0] line_break
    output logic        m_tlast
);

    utf8tl_pkg::dp_cmd_t    cmd;
    utf8tl_pkg::dp_status_t status;
    logic [20:0]            unit;
    logic                   brk;

    utf8tl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    utf8tl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (s_tdata),
        .in_first  (s_tuser[0]),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_unit  (unit),
        .out_brk   (brk),
        .out_last  (m_tlast)
    );

    assign m_tdata = {3'b000, unit};
    assign m_tuser = brk;

    a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new request taken before the previous one finished");

    a_break_has_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[20:0] == 21'd0)
        else $error("line break result carries a nonzero code unit");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        status.res_count <= utf8tl_pkg::MAX_RESULTS)
        else $error("more results than allowed for one request");

    a_load_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> s_tready && s_tvalid)
        else $error("datapath loaded without an accepted request");

endmodule
